// File: hdl/lxc_pkg.sv
// shared types, constants and keyword tables for the lexical token classifier
`default_nettype none

package lxc_pkg;

    localparam int KW_COUNT = 22;
    localparam int LEN_W    = 8;
    localparam int CHAR_W   = 8;
    localparam int CLASS_W  = 3;
    localparam int KWNUM_W  = 5;

    localparam logic [LEN_W-1:0] LEN_MAX = 8'd255;

    // token classes
    localparam logic [CLASS_W-1:0] CLS_OPERATOR   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_KEYWORD    = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_IDENTIFIER = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_INTEGER    = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_INVALID    = 3'd4;

    // characters of interest
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;

    // keyword text, right aligned: last character in the low byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("if"), 64'("else"), 64'("while"), 64'("do"), 64'("break"),
        64'("continue"), 64'("int"), 64'("double"), 64'("float"),
        64'("return"), 64'("char"), 64'("case"), 64'("sizeof"),
        64'("long"), 64'("short"), 64'("typedef"), 64'("switch"),
        64'("unsigned"), 64'("void"), 64'("static"), 64'("struct"),
        64'("goto")
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4,
        4'd4, 4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4
    };

    localparam logic [KW_COUNT-1:0] KW_ALL_ALIVE = '1;

    // state of the token being collected
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [CHAR_W-1:0]   lead;
        logic [CHAR_W-1:0]   second;
        logic [KW_COUNT-1:0] alive;
        logic                ident_ok;
        logic                all_digits;
    } tok_state_t;

    localparam tok_state_t TOK_CLEAR = '{
        len: '0, lead: '0, second: '0, alive: KW_ALL_ALIVE,
        ident_ok: 1'b1, all_digits: 1'b1
    };

    // character at a position of a keyword, valid only below its length
    function automatic logic [CHAR_W-1:0] kw_char(input int k, input logic [2:0] pos);
        logic [2:0] idx;
        idx = 3'(KW_LEN[k] - 4'd1) - pos;
        return KW_TEXT[k][{idx, 3'b000} +: 8];
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

`default_nettype wire

// File: hdl/lexical_token_classifier.sv
// top level of the lexical token classifier: input register, scan, classify, result register
//
// The block takes one character per transaction and splits the stream into tokens at space,
// comma and semicolon; a character with line_end set closes any pending token after it has
// been taken in. Each finished token comes out as one result transaction with its class
// (operator, keyword, identifier, integer, invalid), the keyword index for keywords and its
// length, saturating at 255. Throughput is one character per clock while no result is
// stalled: the keyword match bits, identifier and digit flags all update from the input
// register, and the classification of a closing token is loaded into the result register
// in the same cycle as that update. A token reaches the result register once the character
// that closes it has passed through the input register. While a result waits and is not
// taken, the held character does not move on, so the input register takes at most one more
// character and then stalls the input until the result is taken.
`default_nettype none

module lexical_token_classifier (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // character channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [lxc_pkg::CHAR_W-1:0]  char_code,
    input  wire logic                        line_end,
    // token channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [lxc_pkg::CLASS_W-1:0]      token_class,
    output logic [lxc_pkg::KWNUM_W-1:0]      keyword_number,
    output logic [lxc_pkg::LEN_W-1:0]        token_length
);
    import lxc_pkg::*;

    logic               held_valid;
    logic [CHAR_W-1:0]  held_char;
    logic               held_last;
    logic               advance;
    logic               close_now;
    tok_state_t         close_tok;
    logic [CLASS_W-1:0] cls_comb;
    logic [KWNUM_W-1:0] kw_comb;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CLASS_W-1:0] class_reg;
    logic [KWNUM_W-1:0] kwnum_reg;
    logic [LEN_W-1:0]   length_reg;

    // the held character moves on when the result register has room
    assign advance = held_valid && (!out_valid_reg || out_ready);

    lxc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .line_end   (line_end),
        .advance    (advance),
        .held_valid (held_valid),
        .held_char  (held_char),
        .held_last  (held_last)
    );

    lxc_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .char_in   (held_char),
        .last_in   (held_last),
        .close_now (close_now),
        .close_tok (close_tok)
    );

    lxc_classify u_classify (
        .tok            (close_tok),
        .token_class    (cls_comb),
        .keyword_number (kw_comb)
    );

    // result register: loads on a closing character, empties when taken
    always_comb
    begin
        if (advance && close_now)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && close_now)
        begin
            class_reg  <= cls_comb;
            kwnum_reg  <= kw_comb;
            length_reg <= close_tok.len;
        end
    end

    assign out_valid      = out_valid_reg;
    assign token_class    = class_reg;
    assign keyword_number = kwnum_reg;
    assign token_length   = length_reg;

    // a stalled result never lets the scan move on
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("scan advanced while result stalled");

    // a non-zero keyword index only comes with the keyword class
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kwnum_reg != '0) |-> (class_reg == CLS_KEYWORD))
        else $error("keyword index on a non-keyword token");

    // a result never reports an empty token
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (length_reg != '0))
        else $error("empty token reported");

    // a closing character always produces a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && close_now) |=> out_valid_reg)
        else $error("closed token lost");

endmodule

`default_nettype wire

// File: hdl/lxc_in_reg.sv
// input register holding one character transaction
`default_nettype none

module lxc_in_reg (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [lxc_pkg::CHAR_W-1:0] char_code,
    input  wire logic                     line_end,
    input  wire logic                     advance,
    output logic                          held_valid,
    output logic [lxc_pkg::CHAR_W-1:0]    held_char,
    output logic                          held_last
);
    import lxc_pkg::*;

    logic              vld_reg;
    logic              vld_next;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    assign in_ready = !vld_reg || advance;
    assign vld_next = in_valid ? 1'b1 : (advance ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
            last_reg <= line_end;
        end
    end

    assign held_valid = vld_reg;
    assign held_char  = char_reg;
    assign held_last  = last_reg;

endmodule

`default_nettype wire

// File: hdl/lxc_scan.sv
// token state registers and per-character update
`default_nettype none

module lxc_scan (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [lxc_pkg::CHAR_W-1:0] char_in,
    input  wire logic                       last_in,
    output logic                            close_now,
    output lxc_pkg::tok_state_t             close_tok
);
    import lxc_pkg::*;

    tok_state_t tok_reg;
    tok_state_t tok_next;
    tok_state_t taken;
    logic       delim;
    logic [2:0] pos;

    assign delim = (char_in == CH_SPACE) || (char_in == CH_COMMA) || (char_in == CH_SEMI);
    assign pos   = tok_reg.len[2:0];

    // state after taking in the current character
    always_comb
    begin
        taken = tok_reg;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (!(tok_reg.len < LEN_W'(KW_LEN[k]) && kw_char(k, pos) == char_in))
            begin
                taken.alive[k] = 1'b0;
            end
        end
        if (tok_reg.len == '0)
        begin
            taken.lead = char_in;
            if (!(is_letter(char_in) || char_in == CH_UNDER))
            begin
                taken.ident_ok = 1'b0;
            end
        end
        else
        begin
            if (tok_reg.len == LEN_W'(1))
            begin
                taken.second = char_in;
            end
            if (!(is_letter(char_in) || is_digit(char_in) || char_in == CH_UNDER))
            begin
                taken.ident_ok = 1'b0;
            end
        end
        if (!is_digit(char_in))
        begin
            taken.all_digits = 1'b0;
        end
        if (tok_reg.len != LEN_MAX)
        begin
            taken.len = tok_reg.len + LEN_W'(1);
        end
    end

    // a delimiter closes the stored token, a line end closes the extended one
    assign close_now = delim ? (tok_reg.len != '0) : last_in;
    assign close_tok = delim ? tok_reg : taken;
    assign tok_next  = (delim || last_in) ? TOK_CLEAR : taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= TOK_CLEAR;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lxc_classify.sv
// classification of a finished token
`default_nettype none

module lxc_classify (
    input  wire lxc_pkg::tok_state_t         tok,
    output logic [lxc_pkg::CLASS_W-1:0]      token_class,
    output logic [lxc_pkg::KWNUM_W-1:0]      keyword_number
);
    import lxc_pkg::*;

    logic               is_kw;
    logic [KWNUM_W-1:0] kw_idx;
    logic               is_op;

    // lowest matching keyword index wins
    always_comb
    begin
        is_kw  = 1'b0;
        kw_idx = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (tok.alive[k] && tok.len == LEN_W'(KW_LEN[k]))
            begin
                is_kw  = 1'b1;
                kw_idx = KWNUM_W'(k);
            end
        end
    end

    assign is_op = (tok.lead == CH_PLUS) || (tok.lead == CH_MINUS) ||
                   (tok.lead == CH_STAR) || (tok.lead == CH_SLASH) ||
                   (tok.lead == CH_GT)   || (tok.lead == CH_LT)    ||
                   (tok.lead == CH_EQ)   ||
                   (tok.len == LEN_W'(2) && tok.lead == CH_BANG && tok.second == CH_EQ);

    always_comb
    begin
        keyword_number = '0;
        if (is_op)
        begin
            token_class = CLS_OPERATOR;
        end
        else if (is_kw)
        begin
            token_class    = CLS_KEYWORD;
            keyword_number = kw_idx;
        end
        else if (tok.ident_ok)
        begin
            token_class = CLS_IDENTIFIER;
        end
        else if (tok.all_digits)
        begin
            token_class = CLS_INTEGER;
        end
        else
        begin
            token_class = CLS_INVALID;
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_lexical_token_classifier.sv
// self-checking testbench for the lexical token classifier: random character streams, scoreboard
`timescale 1ns / 1ps

module tb_lexical_token_classifier;

    import lxc_pkg::*;

    // run limits and pressure settings
    localparam int CLK_HALF   = 5;
    localparam int LIMIT_NS   = 3_000_000;
    localparam int LONG_STALL = 400;
    localparam int DRAIN_MAX  = 20_000;
    localparam int PRINT_MAX  = 100;

    // one character transaction as the sender sees it
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_item_t;

    // one token transaction as the receiver sees it
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [KWNUM_W-1:0] kw;
        logic [LEN_W-1:0]   len;
    } token_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CHAR_W-1:0]  char_code = '0;
    logic               line_end = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CLASS_W-1:0] token_class;
    logic [KWNUM_W-1:0] keyword_number;
    logic [LEN_W-1:0]   token_length;

    lexical_token_classifier uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_code      (char_code),
        .line_end       (line_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_class    (token_class),
        .keyword_number (keyword_number),
        .token_length   (token_length)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // keyword spellings in index order, and character pools for stimulus
    string kw_spell [KW_COUNT] = '{
        "if", "else", "while", "do", "break", "continue", "int", "double",
        "float", "return", "char", "case", "sizeof", "long", "short",
        "typedef", "switch", "unsigned", "void", "static", "struct", "goto"
    };
    // letters at 0..51, underscore at 52, digits at 53..62
    string ident_pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
    string op_pool    = "+-*/><=";

    // stimulus waiting to be offered, tokens predicted but not yet seen
    char_item_t     chars_pending [$];
    token_t         tokens_due [$];
    logic [7:0]     word_buf [$];

    // shared counters; each but errors has exactly one writing process
    int chars_queued   = 0;
    int chars_offered  = 0;
    int chars_accepted = 0;
    int tokens_taken   = 0;
    int tokens_noted   = 0;
    int tokens_checked = 0;
    int stalls_asked   = 0;
    int stalls_granted = 0;
    int errors         = 0;
    int send_wait      = 0;
    int recv_wait      = 0;
    int class_tally [5] = '{0, 0, 0, 0, 0};
    bit idle_on        = 1'b1;

    // predictor copy of the token being collected
    logic [LEN_W-1:0]    tok_len     = '0;
    logic [CHAR_W-1:0]   tok_first   = '0;
    logic [CHAR_W-1:0]   tok_second  = '0;
    logic [KW_COUNT-1:0] kw_live     = '1;
    bit                  tok_ident   = 1'b1;
    bit                  tok_numeric = 1'b1;

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= PRINT_MAX)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    function automatic bit char_is_break(input logic [7:0] c);
        return c == CH_SPACE || c == CH_COMMA || c == CH_SEMI;
    endfunction

    function automatic bit char_is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit char_is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // classify the collected token, queue it as expected, start afresh
    task automatic lex_emit();
        token_t t;
        bit     kw_hit;
        bit     is_op;
        int     k;
        kw_hit = 1'b0;
        t.kw   = '0;
        // descending scan so the lowest matching index wins
        for (k = KW_COUNT - 1; k >= 0; k--)
            if (kw_live[k] && kw_spell[k].len() == int'(tok_len))
            begin
                kw_hit = 1'b1;
                t.kw   = KWNUM_W'(k);
            end
        is_op = tok_first == CH_PLUS || tok_first == CH_MINUS || tok_first == CH_STAR ||
                tok_first == CH_SLASH || tok_first == CH_GT || tok_first == CH_LT ||
                tok_first == CH_EQ ||
                (tok_len == 8'd2 && tok_first == CH_BANG && tok_second == CH_EQ);
        if (is_op)
            t.cls = CLS_OPERATOR;
        else if (kw_hit)
            t.cls = CLS_KEYWORD;
        else if (tok_ident)
            t.cls = CLS_IDENTIFIER;
        else if (tok_numeric)
            t.cls = CLS_INTEGER;
        else
            t.cls = CLS_INVALID;
        if (t.cls != CLS_KEYWORD)
            t.kw = '0;
        t.len = tok_len;
        tokens_due.push_back(t);
        class_tally[t.cls]++;
        tok_len     = '0;
        tok_first   = '0;
        tok_second  = '0;
        kw_live     = '1;
        tok_ident   = 1'b1;
        tok_numeric = 1'b1;
    endtask

    // fold one accepted character into the predictor
    task automatic lex_absorb(input logic [7:0] c, input logic last);
        int k;
        if (char_is_break(c))
        begin
            // delimiters are dropped; they only close what is pending
            if (tok_len != 0)
                lex_emit();
        end
        else
        begin
            for (k = 0; k < KW_COUNT; k++)
                if (!(int'(tok_len) < kw_spell[k].len() &&
                      8'(kw_spell[k][int'(tok_len)]) == c))
                    kw_live[k] = 1'b0;
            if (tok_len == 0)
            begin
                tok_first = c;
                if (!(char_is_letter(c) || c == CH_UNDER))
                    tok_ident = 1'b0;
            end
            else
            begin
                if (tok_len == 8'd1)
                    tok_second = c;
                if (!(char_is_letter(c) || char_is_digit(c) || c == CH_UNDER))
                    tok_ident = 1'b0;
            end
            if (!char_is_digit(c))
                tok_numeric = 1'b0;
            // length saturates, class flags keep tracking
            if (tok_len != LEN_MAX)
                tok_len = tok_len + 1'b1;
            if (last)
                lex_emit();
        end
    endtask

    // compare one received token against the oldest prediction
    task automatic check_token();
        token_t want;
        if (tokens_due.size() == 0)
            flag_error($sformatf("unexpected token: class %0d keyword %0d length %0d",
                                 token_class, keyword_number, token_length));
        else
        begin
            want = tokens_due.pop_front();
            if (token_class !== want.cls)
                flag_error($sformatf("token %0d class: got %0d want %0d",
                                     tokens_checked, token_class, want.cls));
            if (keyword_number !== want.kw)
                flag_error($sformatf("token %0d keyword: got %0d want %0d",
                                     tokens_checked, keyword_number, want.kw));
            if (token_length !== want.len)
                flag_error($sformatf("token %0d length: got %0d want %0d",
                                     tokens_checked, token_length, want.len));
            tokens_checked++;
        end
    endtask

    // sender: offers queued characters at the falling edge, random gap after each while idling is on
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // hold the current transaction until it has been taken
            if (!(in_valid && chars_accepted != chars_offered))
            begin
                if (send_wait != 0)
                begin
                    send_wait = send_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (chars_pending.size() != 0)
                begin
                    char_code <= chars_pending[0].code;
                    line_end  <= chars_pending[0].last;
                    in_valid  <= 1'b1;
                    void'(chars_pending.pop_front());
                    chars_offered = chars_offered + 1;
                    send_wait = idle_on ? $urandom_range(0, 15) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random hold-off per token while idling is on, plus long stalls on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (tokens_taken != tokens_noted)
            begin
                tokens_noted = tokens_taken;
                recv_wait = idle_on ? $urandom_range(0, 15) : 0;
            end
            // a long stall lets the sender run into a full pipeline
            if (stalls_granted != stalls_asked)
            begin
                stalls_granted = stalls_granted + 1;
                recv_wait = LONG_STALL;
            end
            if (recv_wait != 0)
            begin
                recv_wait = recv_wait - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: both handshakes sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                lex_absorb(char_code, line_end);
                chars_accepted <= chars_accepted + 1;
            end
            if (out_valid && out_ready)
            begin
                check_token();
                tokens_taken <= tokens_taken + 1;
            end
        end
    end

    task automatic queue_char(input logic [7:0] c, input logic last);
        char_item_t it;
        it.code = c;
        it.last = last;
        chars_pending.push_back(it);
        chars_queued++;
    endtask

    task automatic queue_text(input string s, input logic last_on_end);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_char(8'(s[i]), last_on_end && i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_body_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (char_is_break(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] rand_break_char();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_COMMA;
            default: return CH_SEMI;
        endcase
    endfunction

    // fill word_buf with one token-shaped lexeme of a random kind
    task automatic build_lexeme();
        string w;
        int    n;
        int    i;
        word_buf.delete();
        case ($urandom_range(0, 7))
            0:
            begin
                w = kw_spell[$urandom_range(0, KW_COUNT - 1)];
                for (i = 0; i < w.len(); i++)
                    word_buf.push_back(8'(w[i]));
            end
            1:
            begin
                // keyword prefix, exact, or keyword with extra characters
                w = kw_spell[$urandom_range(0, KW_COUNT - 1)];
                n = $urandom_range(1, w.len() + 2);
                for (i = 0; i < n; i++)
                    word_buf.push_back(i < w.len() ? 8'(w[i]) :
                                       8'(ident_pool[$urandom_range(0, 62)]));
            end
            2:
            begin
                word_buf.push_back(8'(ident_pool[$urandom_range(0, 52)]));
                n = $urandom_range(0, 9);
                for (i = 0; i < n; i++)
                    word_buf.push_back(8'(ident_pool[$urandom_range(0, 62)]));
            end
            3:
            begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    word_buf.push_back(8'(ident_pool[$urandom_range(53, 62)]));
            end
            4:
            begin
                word_buf.push_back(8'(op_pool[$urandom_range(0, 6)]));
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    word_buf.push_back(rand_body_char());
            end
            5:
            begin
                // not-equal exactly, with a tail, or a lone bang
                word_buf.push_back(CH_BANG);
                n = $urandom_range(0, 2);
                if (n != 0)
                    word_buf.push_back(CH_EQ);
                if (n == 2)
                    word_buf.push_back(rand_body_char());
            end
            6:
            begin
                word_buf.push_back(8'(ident_pool[$urandom_range(53, 62)]));
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                    word_buf.push_back(8'(ident_pool[$urandom_range(0, 62)]));
            end
            default:
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    word_buf.push_back(rand_body_char());
            end
        endcase
    endtask

    // send word_buf, then close it one of several ways
    task automatic end_lexeme();
        int how;
        int i;
        int n;
        how = $urandom_range(0, 3);
        for (i = 0; i < word_buf.size(); i++)
            queue_char(word_buf[i], how == 2 && i == word_buf.size() - 1);
        if (how < 2)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                queue_char(rand_break_char(), 1'b0);
        end
        else if (how == 3)
            queue_char(rand_break_char(), 1'b1);
    endtask

    // mostly well-formed tokens, some raw noise bytes
    task automatic random_phase(input int n);
        int stop_at;
        stop_at = chars_queued + n;
        while (chars_queued < stop_at)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                build_lexeme();
                end_lexeme();
            end
            else
                queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
    endtask

    // let the sender run dry, then wait for every predicted token
    task automatic wait_for_drain();
        int cycles;
        while (chars_pending.size() != 0 || chars_accepted != chars_offered)
            @(posedge clk);
        cycles = 0;
        while (tokens_due.size() != 0 && cycles < DRAIN_MAX)
        begin
            @(posedge clk);
            cycles++;
        end
        if (tokens_due.size() != 0)
        begin
            flag_error($sformatf("%0d predicted tokens never arrived", tokens_due.size()));
            tokens_due.delete();
        end
        // latency cushion so any stray output still shows up
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int i;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: each class, delimiter runs, line-end variants, code extremes
        queue_text("if", 1'b0);
        queue_char(CH_SPACE, 1'b0);
        queue_text("!=", 1'b0);
        queue_char(CH_COMMA, 1'b0);
        queue_text("+", 1'b0);
        queue_char(CH_SEMI, 1'b0);
        queue_text("_a9", 1'b1);
        queue_text("42", 1'b0);
        queue_char(CH_SPACE, 1'b0);
        queue_char(CH_SPACE, 1'b0);
        queue_text("!x", 1'b0);
        queue_char(CH_SEMI, 1'b0);
        queue_text("goto", 1'b0);
        queue_char(CH_SPACE, 1'b1);
        queue_char(CH_SEMI, 1'b1);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(CH_COMMA, 1'b0);
        // sender pauses here until every token has come back
        wait_for_drain();

        // random traffic with idling on both sides
        random_phase(250);
        wait_for_drain();

        // back to back traffic against a long receiver stall
        idle_on = 1'b0;
        stalls_asked++;
        random_phase(200);
        wait_for_drain();

        // overlong tokens: one exactly at saturation, one well past it
        for (i = 0; i < 255; i++)
            queue_char(8'(ident_pool[$urandom_range(0, 51)]), 1'b0);
        queue_char(CH_SPACE, 1'b0);
        for (i = 0; i < 290; i++)
            queue_char(8'(ident_pool[$urandom_range(53, 62)]), i == 289);
        wait_for_drain();

        // idling again, with a second long stall in the middle of traffic
        idle_on = 1'b1;
        random_phase(80);
        stalls_asked++;
        random_phase(70);
        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("summary: %0d characters, %0d tokens checked, %0d long receiver stalls",
                 chars_accepted, tokens_checked, stalls_granted);
        $display("summary: operator %0d keyword %0d identifier %0d integer %0d invalid %0d",
                 class_tally[0], class_tally[1], class_tally[2], class_tally[3],
                 class_tally[4]);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #LIMIT_NS;
        $display("timeout after %0d ns", LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
